/* rtl/tst_pkg.sv */
// Shared types and constants for the timing statistics table.
`timescale 1ns / 1ps
package tst_pkg;
   localparam logic [1:0] STATUS_UPDATED  = 2'd0;
   localparam logic [1:0] STATUS_INSERTED = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   // classified item passed from the lookup front to the update back
   typedef struct packed {
      logic        hit;
      logic        full;
      logic [9:0]  slot;
      logic [31:0] duration;
      logic [47:0] now_time;
   } job_type;

   // per-slot statistics record stored in RAM
   typedef struct packed {
      logic [47:0] total;
      logic [31:0] count;
      logic [31:0] max_time;
      logic [31:0] win_max;
      logic [31:0] win_min;
      logic [31:0] last;
      logic [47:0] win_start;
   } stats_type;

   // result item fields
   typedef struct packed {
      logic [31:0] window_max;
      logic [31:0] window_min;
      logic [31:0] max_time;
      logic [47:0] total_time;
      logic [31:0] call_count;
      logic [5:0]  entry_index;
      logic [1:0]  status;
   } rsp_type;
endpackage

/* rtl/tst_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module tst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/tst_front.sv */
// Lookup front: matches key and line across the tag cells and picks a slot.
`timescale 1ns / 1ps
module tst_front #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [31:0]      site_key,
   input  logic [19:0]      site_line,
   input  logic [31:0]      duration,
   input  logic [47:0]      now_time,
   output logic             job_valid,
   input  logic             job_ready,
   output tst_pkg::job_type job
);
   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0]              key_ff  [TABLE_ENTRIES];
   logic [19:0]              line_ff [TABLE_ENTRIES];
   logic [CW-1:0]            used_ff, used_in;
   logic                     job_valid_ff, job_valid_in;
   tst_pkg::job_type         job_ff, job_in;
   logic [TABLE_ENTRIES-1:0] match;
   logic [AW-1:0]            hit_idx;
   logic                     any_hit, full, insert, take;

   // lookup is combinational; a single registered job slot decouples from the back part
   assign in_ready = !job_valid_ff || job_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         match[i] = valid_ff[i] && key_ff[i] == site_key && line_ff[i] == site_line;
      end
   end

   always_comb begin
      hit_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = AW'(i);
         end
      end
   end

   assign any_hit = |match;
   assign full    = used_ff == CW'(TABLE_ENTRIES);
   assign insert  = take && !any_hit && !full;

   always_comb begin
      valid_in     = valid_ff;
      used_in      = used_ff;
      job_valid_in = job_valid_ff;
      job_in       = job_ff;
      if (job_ready) begin
         job_valid_in = 1'b0;
      end
      if (take) begin
         job_valid_in    = 1'b1;
         job_in.hit      = any_hit;
         job_in.full     = !any_hit && full;
         job_in.slot     = any_hit ? 10'(hit_idx) : 10'(used_ff[AW-1:0]);
         job_in.duration = duration;
         job_in.now_time = now_time;
      end
      if (insert) begin
         valid_in[used_ff[AW-1:0]] = 1'b1;
         used_in = used_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         used_ff      <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         used_ff      <= used_in;
         job_valid_ff <= job_valid_in;
      end
      job_ff <= job_in;
      if (insert) begin
         key_ff[used_ff[AW-1:0]]  <= site_key;
         line_ff[used_ff[AW-1:0]] <= site_line;
      end
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;
endmodule

/* rtl/tst_back.sv */
// Update back: read-modify-write of one slot's statistics record.
`timescale 1ns / 1ps
module tst_back #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [31:0]      window_period,
   input  logic             job_valid,
   output logic             job_ready,
   input  tst_pkg::job_type job,
   output logic             out_valid,
   input  logic             out_ready,
   output tst_pkg::rsp_type out_data
);
   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]          state_ff, state_in;
   tst_pkg::job_type    cur_ff;
   tst_pkg::stats_type  rd_data, nx;
   tst_pkg::rsp_type    rsp_ff, rsp_in;
   logic                wr_en;
   logic [48:0]         sum;
   logic [47:0]         elapsed;
   logic [31:0]         d;

   tst_ram #(.WIDTH($bits(tst_pkg::stats_type)), .DEPTH(TABLE_ENTRIES)) u_stats (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(cur_ff.slot[AW-1:0]),
      .wr_data(nx),
      .rd_addr(job.slot[AW-1:0]),
      .rd_data(rd_data)
   );

   assign job_ready = state_ff == ST_IDLE;
   assign out_valid = state_ff == ST_OUT;
   assign out_data  = rsp_ff;
   assign d         = cur_ff.duration;
   assign sum       = {1'b0, rd_data.total} + 49'(d);
   assign elapsed   = cur_ff.now_time - rd_data.win_start;

   // statistics update for a hit, or a fresh record for an insert
   always_comb begin
      nx = rd_data;
      if (cur_ff.hit) begin
         nx.total    = sum[48] ? '1 : sum[47:0];
         nx.count    = (rd_data.count == '1) ? rd_data.count : rd_data.count + 1'b1;
         nx.max_time = (d > rd_data.max_time) ? d : rd_data.max_time;
         nx.win_max  = (d > rd_data.win_max) ? d : rd_data.win_max;
         nx.win_min  = (d != '0 && d < rd_data.win_min) ? d : rd_data.win_min;
         nx.last     = d;
         if (elapsed > 48'(window_period)) begin
            nx.win_start = cur_ff.now_time;
            nx.win_min   = d;
            nx.win_max   = d;
         end
      end else begin
         nx.total     = 48'(d);
         nx.count     = 32'd1;
         nx.max_time  = d;
         nx.win_max   = d;
         nx.win_min   = d;
         nx.last      = d;
         nx.win_start = cur_ff.now_time;
      end
   end

   assign wr_en = state_ff == ST_READ && !cur_ff.full;

   always_comb begin
      state_in = state_ff;
      rsp_in   = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_OUT;
            if (cur_ff.full) begin
               rsp_in        = '0;
               rsp_in.status = tst_pkg::STATUS_FULL;
            end else begin
               rsp_in.status      = cur_ff.hit ? tst_pkg::STATUS_UPDATED
                                               : tst_pkg::STATUS_INSERTED;
               rsp_in.entry_index = cur_ff.slot[5:0];
               rsp_in.call_count  = nx.count;
               rsp_in.total_time  = nx.total;
               rsp_in.max_time    = nx.max_time;
               rsp_in.window_min  = nx.win_min;
               rsp_in.window_max  = nx.win_max;
            end
         end
         ST_OUT: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rsp_ff <= rsp_in;
      if (state_ff == ST_IDLE && job_valid) begin
         cur_ff <= job;
      end
   end
endmodule

/* rtl/timing_statistics_table.sv */
// Top level of the timing statistics table.
`timescale 1ns / 1ps
// Per-site timing statistics. Each request item carries a site key and line, a
// duration and the current time; the front matches key and line against all
// tag cells and reserves a new slot on a miss, then hands the item to the back,
// which reads the slot's statistics RAM, updates it and writes it back. The
// back goes from idle (takes the item, issues the read) to read (updates and
// writes the record) to output (holds the result until taken) and takes no new
// item until idle again; the front can hold one more meanwhile. Slots fill in
// order and are never freed; a full table gives status 2, other fields zero.
module timing_statistics_table #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // site_key[31:0], site_line[51:32], duration[83:52], now_time[131:84], zero pad
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], entry_index[7:2], call_count[39:8], total_time[87:40],
   // max_time[119:88], window_min[151:120], window_max[183:152]
   output logic [183:0] rsp_tdata
);
   logic [31:0]      window_period_ff;
   logic             job_valid, job_ready;
   tst_pkg::job_type job;
   tst_pkg::rsp_type rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_period_ff <= 32'd60000;
      end else if (csr_wr_en) begin
         window_period_ff <= csr_wr_data;
      end
   end

   tst_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .site_key (req_tdata[31:0]),
      .site_line(req_tdata[51:32]),
      .duration (req_tdata[83:52]),
      .now_time (req_tdata[131:84]),
      .job_valid(job_valid),
      .job_ready(job_ready),
      .job      (job)
   );

   tst_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock        (clock),
      .reset        (reset),
      .window_period(window_period_ff),
      .job_valid    (job_valid),
      .job_ready    (job_ready),
      .job          (job),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_data     (rsp)
   );

   assign rsp_tdata = rsp;
endmodule
